/* design/jet_pair_mass_window_search_defines.svh */
// Assertion macros used by the search module.
`ifndef JET_PAIR_MASS_WINDOW_SEARCH_DEFINES_SVH
`define JET_PAIR_MASS_WINDOW_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JPMWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define JPMWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/jpmws_pkg.sv */
package jpmws_pkg;

    localparam int MAX_JETS_DEF = 16;
    localparam int JET_W        = 64;
    localparam int WIN_W        = 36;
    localparam int REG_IDX_W    = 3;
    localparam int COMP_W       = 19;
    localparam int SQ_W         = 2 * COMP_W;
    localparam int MASS_W       = 40;

    localparam logic [REG_IDX_W-1:0] REG_PAIR0_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAIR0_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAIR1_MIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAIR1_MAX = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_QUAD_MIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_QUAD_MAX  = 3'd5;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t e;
        comp_t x;
        comp_t y;
        comp_t z;
    } vec_t;

    // Which window the mass accumulator is currently evaluated against.
    typedef enum logic [1:0] {
        PH_PAIR0 = 2'd0,
        PH_PAIR1 = 2'd1,
        PH_QUAD  = 2'd2
    } phase_t;

    // Stored word layout matches the input tdata: E, px, py, pz from bit 0 up.
    function automatic vec_t jet_decode(input logic [JET_W-1:0] w);
        vec_t v;
        v.e = comp_t'({3'b000, w[15:0]});
        v.x = comp_t'({{3{w[31]}}, w[31:16]});
        v.y = comp_t'({{3{w[47]}}, w[47:32]});
        v.z = comp_t'({{3{w[63]}}, w[63:48]});
        return v;
    endfunction

    function automatic vec_t vec_add(input vec_t a, input vec_t b);
        vec_t v;
        v.e = a.e + b.e;
        v.x = a.x + b.x;
        v.y = a.y + b.y;
        v.z = a.z + b.z;
        return v;
    endfunction

endpackage

/* design/jpmws_ram.sv */
module jpmws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/jet_pair_mass_window_search.sv */
// Jet pair mass window search.
// Input stream (s_axis): one jet per transfer, tdata = E, px, py, pz from bit 0
// up, tlast marks the final jet of an event. Jets are written into the jet
// store; up to MAX_JETS are kept, later ones are dropped and flagged.
// Output stream (m_axis): one transfer per event, tdata bit 0 is the pass flag
// and bit 1 says jets were dropped.
// Configuration: cfg_we/cfg_addr/cfg_data write the six 36-bit mass-squared
// bounds, index 0 to 5. The user must write them only while the block is idle;
// the block does not enforce this. A jet that is not the last is only stored.
// After the last jet the block walks every pair A (i<j) and, for each pair A
// whose mass falls in its window, every disjoint pair B (k<l). A pair A runs
// through ST_RD_A0, ST_RD_A1 and ST_SUM_A (two store reads), ST_MASS, a mass
// unit built around a single 18x18 squarer of the component magnitude, and
// ST_CHECK. A pair B first passes ST_PICK_KL, which skips one that shares a
// jet with A, then the same steps with ST_RD_B0, ST_RD_B1 and ST_SUM_B. If B
// hits too, a quad check of the four-jet sum repeats ST_MASS and ST_CHECK.
// With fewer than four jets no search runs and the result goes out through
// done_pend_reg. The search stops at the first qualifying pairing.
// Reset clears the counters and sets the windows to their full range; the
// store content is not cleared. A stalled receiver holds the result in the
// output register; jets of the next event still load meanwhile, but once that
// event's result is ready the input stalls until the register frees up.
`include "jet_pair_mass_window_search_defines.svh"

module jet_pair_mass_window_search #(
    parameter int MAX_JETS = jpmws_pkg::MAX_JETS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // jet_energy[15:0], jet_px[31:16], jet_py[47:32], jet_pz[63:48]
    input  logic [63:0]                        s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // event_passes[0], jets_dropped[1], zero fill [7:2]
    output logic [7:0]                         m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [jpmws_pkg::REG_IDX_W-1:0]    cfg_addr,
    input  logic [jpmws_pkg::WIN_W-1:0]        cfg_data
);

    localparam int IDXW = $clog2(MAX_JETS);
    localparam int CNTW = $clog2(MAX_JETS + 1);

    typedef enum logic [9:0] {
        ST_LOAD    = 10'b0000000001,
        ST_RD_A0   = 10'b0000000010,
        ST_RD_A1   = 10'b0000000100,
        ST_SUM_A   = 10'b0000001000,
        ST_PICK_KL = 10'b0000010000,
        ST_RD_B0   = 10'b0000100000,
        ST_RD_B1   = 10'b0001000000,
        ST_SUM_B   = 10'b0010000000,
        ST_MASS    = 10'b0100000000,
        ST_CHECK   = 10'b1000000000
    } state_t;

    // Result-ready is folded into ST_LOAD with done_pend_reg so that loading goes on
    // while the output stalls, until a second result is pending.
    state_t state_reg, state_next;

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [CNTW-1:0] n_reg, n_next;
    logic            drop_reg, drop_next;
    logic [CNTW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, l_reg, l_next;
    logic            pass_reg, pass_next;
    logic            done_pend_reg, done_pend_next;
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_data_reg, m_data_next;
    logic [2:0]      mc_reg, mc_next;
    jpmws_pkg::phase_t ph_reg, ph_next;

    logic [jpmws_pkg::WIN_W-1:0] win_min_reg [3];
    logic [jpmws_pkg::WIN_W-1:0] win_max_reg [3];

    jpmws_pkg::vec_t va_reg, va_next, vb_reg, vb_next;
    logic [jpmws_pkg::SQ_W-1:0] mul_reg, mul_next;
    logic signed [jpmws_pkg::MASS_W-1:0] acc_reg, acc_next;

    logic                        ram_we;
    logic [IDXW-1:0]             ram_raddr;
    logic [jpmws_pkg::JET_W-1:0] ram_rdata;

    jpmws_pkg::vec_t mvec, rjet;
    jpmws_pkg::comp_t comp;
    logic [jpmws_pkg::COMP_W-2:0]   mag;
    logic [2*jpmws_pkg::COMP_W-3:0] sq;
    logic signed [jpmws_pkg::MASS_W-1:0] lo_bound, hi_bound;
    logic            hit, s_acc, m_free, overlap;
    logic [CNTW-1:0] cnt_inc;

    assign s_axis_tready = (state_reg == ST_LOAD) && !done_pend_reg;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign ram_we        = s_acc && (cnt_reg < CNTW'(MAX_JETS));
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b000000, m_data_reg};
    assign m_free        = !m_valid_reg || m_axis_tready;
    assign rjet          = jpmws_pkg::jet_decode(ram_rdata);
    assign cnt_inc       = cnt_reg + CNTW'(1);

    jpmws_ram #(
        .WIDTH (jpmws_pkg::JET_W),
        .DEPTH (MAX_JETS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDXW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Mass unit operand: the pair being tested or the four-jet sum.
    always_comb
    begin
        case (ph_reg)
            jpmws_pkg::PH_PAIR0: mvec = va_reg;
            jpmws_pkg::PH_PAIR1: mvec = vb_reg;
            default:             mvec = jpmws_pkg::vec_add(va_reg, vb_reg);
        endcase
        case (mc_reg[1:0])
            2'd0:    comp = mvec.e;
            2'd1:    comp = mvec.x;
            2'd2:    comp = mvec.y;
            default: comp = mvec.z;
        endcase
        // Every summed component has a magnitude below 2^18, so squaring the
        // magnitude gives the exact square.
        mag = comp[jpmws_pkg::COMP_W-1] ? (jpmws_pkg::COMP_W-1)'(-comp) :
                                          (jpmws_pkg::COMP_W-1)'(comp);
        sq  = mag * mag;
        lo_bound = jpmws_pkg::MASS_W'($signed({1'b0, win_min_reg[ph_reg]}));
        hi_bound = jpmws_pkg::MASS_W'($signed({1'b0, win_max_reg[ph_reg]}));
        hit      = (acc_reg >= lo_bound) && (acc_reg < hi_bound);
        overlap  = (k_reg == i_reg) || (k_reg == j_reg) ||
                   (l_reg == i_reg) || (l_reg == j_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        pass_next      = pass_reg;
        done_pend_next = done_pend_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        mc_next        = mc_reg;
        ph_next        = ph_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        mul_next       = mul_reg;
        acc_next       = acc_reg;
        ram_raddr      = i_reg[IDXW-1:0];

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (done_pend_reg && m_free)
        begin
            m_valid_next   = 1'b1;
            m_data_next    = {drop_reg, pass_reg};
            done_pend_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    if (cnt_reg < CNTW'(MAX_JETS))
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        n_next    = (cnt_reg < CNTW'(MAX_JETS)) ? cnt_inc : cnt_reg;
                        drop_next = ovf_next;
                        cnt_next  = '0;
                        ovf_next  = 1'b0;
                        i_next    = '0;
                        j_next    = CNTW'(1);
                        if (n_next < CNTW'(4))
                        begin
                            pass_next      = 1'b0;
                            done_pend_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_RD_A0;
                        end
                    end
                end
            end
            ST_RD_A0:
            begin
                ram_raddr  = i_reg[IDXW-1:0];
                state_next = ST_RD_A1;
            end
            ST_RD_A1:
            begin
                ram_raddr  = j_reg[IDXW-1:0];
                va_next    = rjet;
                state_next = ST_SUM_A;
            end
            ST_SUM_A:
            begin
                va_next    = jpmws_pkg::vec_add(va_reg, rjet);
                ph_next    = jpmws_pkg::PH_PAIR0;
                mc_next    = '0;
                state_next = ST_MASS;
            end
            ST_PICK_KL:
            begin
                state_next = ST_RD_B0;
            end
            ST_RD_B0:
            begin
                ram_raddr  = k_reg[IDXW-1:0];
                state_next = ST_RD_B1;
            end
            ST_RD_B1:
            begin
                ram_raddr  = l_reg[IDXW-1:0];
                vb_next    = rjet;
                state_next = ST_SUM_B;
            end
            ST_SUM_B:
            begin
                vb_next    = jpmws_pkg::vec_add(vb_reg, rjet);
                ph_next    = jpmws_pkg::PH_PAIR1;
                mc_next    = '0;
                state_next = ST_MASS;
            end
            ST_MASS:
            begin
                // Square one component per cycle; accumulate the registered square.
                mul_next = jpmws_pkg::SQ_W'(sq);
                if (mc_reg == 3'd0)
                begin
                    acc_next = '0;
                end
                else if (mc_reg == 3'd1)
                begin
                    acc_next = acc_reg + jpmws_pkg::MASS_W'(mul_reg);
                end
                else
                begin
                    acc_next = acc_reg - jpmws_pkg::MASS_W'(mul_reg);
                end
                mc_next = mc_reg + 3'd1;
                if (mc_reg == 3'd4)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (hit && ph_reg == jpmws_pkg::PH_PAIR1)
                begin
                    ph_next    = jpmws_pkg::PH_QUAD;
                    mc_next    = '0;
                    state_next = ST_MASS;
                end
                else if (hit && ph_reg == jpmws_pkg::PH_QUAD)
                begin
                    pass_next      = 1'b1;
                    done_pend_next = 1'b1;
                    state_next     = ST_LOAD;
                end
                else if (hit)
                begin
                    k_next     = '0;
                    l_next     = CNTW'(1);
                    state_next = ST_PICK_KL;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Pick the next candidate pair B, skipping any that shares a jet with A,
        // and fall back to the next pair A when the B list runs out.
        if ((state_reg == ST_PICK_KL && overlap) ||
            (state_reg == ST_CHECK && !hit && ph_reg != jpmws_pkg::PH_PAIR0))
        begin
            if (l_reg + CNTW'(1) < n_reg)
            begin
                l_next     = l_reg + CNTW'(1);
                state_next = ST_PICK_KL;
            end
            else if (k_reg + CNTW'(2) < n_reg)
            begin
                k_next     = k_reg + CNTW'(1);
                l_next     = k_reg + CNTW'(2);
                state_next = ST_PICK_KL;
            end
            else
            begin
                state_next = ST_RD_A0;
            end
        end
        if ((state_reg == ST_CHECK && !hit && ph_reg == jpmws_pkg::PH_PAIR0) ||
            (state_next == ST_RD_A0 && state_reg != ST_LOAD))
        begin
            if (j_reg + CNTW'(1) < n_reg)
            begin
                j_next     = j_reg + CNTW'(1);
                state_next = ST_RD_A0;
            end
            else if (i_reg + CNTW'(2) < n_reg)
            begin
                i_next     = i_reg + CNTW'(1);
                j_next     = i_reg + CNTW'(2);
                state_next = ST_RD_A0;
            end
            else
            begin
                pass_next      = 1'b0;
                done_pend_next = 1'b1;
                state_next     = ST_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            l_reg         <= '0;
            pass_reg      <= 1'b0;
            done_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            mc_reg        <= '0;
            ph_reg        <= jpmws_pkg::PH_PAIR0;
            for (int w = 0; w < 3; w++)
            begin
                win_min_reg[w] <= '0;
                win_max_reg[w] <= '1;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            l_reg         <= l_next;
            pass_reg      <= pass_next;
            done_pend_reg <= done_pend_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            mc_reg        <= mc_next;
            ph_reg        <= ph_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    jpmws_pkg::REG_PAIR0_MIN: win_min_reg[0] <= cfg_data;
                    jpmws_pkg::REG_PAIR0_MAX: win_max_reg[0] <= cfg_data;
                    jpmws_pkg::REG_PAIR1_MIN: win_min_reg[1] <= cfg_data;
                    jpmws_pkg::REG_PAIR1_MAX: win_max_reg[1] <= cfg_data;
                    jpmws_pkg::REG_QUAD_MIN:  win_min_reg[2] <= cfg_data;
                    jpmws_pkg::REG_QUAD_MAX:  win_max_reg[2] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg  <= va_next;
        vb_reg  <= vb_next;
        mul_reg <= mul_next;
        acc_reg <= acc_next;
    end

    `JPMWS_ASSERT_NEXT(a_last_starts_search, s_acc && s_axis_tlast, !s_axis_tready,
        "input still taken right after the last jet")
    `JPMWS_ASSERT_NOW(a_pair_a_order, state_reg == ST_RD_A0,
        i_reg < j_reg && j_reg < n_reg, "pair A indices out of order")
    `JPMWS_ASSERT_NOW(a_pair_b_order, state_reg == ST_PICK_KL,
        k_reg < l_reg && l_reg < n_reg, "pair B indices out of order")
    `JPMWS_ASSERT_NOW(a_count_bound, 1'b1, cnt_reg <= CNTW'(MAX_JETS),
        "jet count beyond store size")

endmodule
